// ===== src/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants for the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int MAX_ROM_BANKS_DEF = 128;
  localparam int CLK_BYTES         = 5;
  localparam int CLK_IDX_W         = $clog2(CLK_BYTES);
  localparam int ADDR_W            = 16;
  localparam int MAP_W             = 21;
  localparam int BYTE_W            = 8;
  localparam int ROM_BANK_W        = 7;
  localparam int ROM_CNT_W         = 8;
  localparam int RAM_CNT_W         = 3;
  localparam int CFG_IDX_W         = 1;

  localparam logic [3:0]           RAM_ENABLE_KEY  = 4'hA;
  localparam logic [3:0]           CLK_SEL_FIRST   = 4'h8;
  localparam logic [3:0]           CLK_SEL_LAST    = 4'hC;
  localparam logic [BYTE_W-1:0]    RAM_SEL_MAX     = 8'h03;
  localparam logic [RAM_CNT_W-1:0] RAM_CNT_RST     = 3'd4;

  typedef enum logic [2:0] {
    TGT_NONE   = 3'd0,
    TGT_ROM    = 3'd1,
    TGT_RAM    = 3'd2,
    TGT_DATA   = 3'd3,
    TGT_ABSORB = 3'd4
  } cbm_target_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROM_BANK_COUNT = 1'b0,
    CFG_RAM_BANK_COUNT = 1'b1
  } cbm_cfg_idx_e;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] bus_address;
    logic [BYTE_W-1:0] write_byte;
  } cbm_req_t;

  typedef struct packed {
    logic [2:0]        target;
    logic [MAP_W-1:0]  mapped_address;
    logic [BYTE_W-1:0] read_byte;
    logic              ram_write;
  } cbm_rsp_t;

  typedef struct packed {
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [3:0]            ram_en;
    logic [3:0]            ram_sel;
    logic                  use_ram;
  } cbm_state_t;

  typedef struct packed {
    logic [ROM_CNT_W-1:0] rom_cnt;
    logic [RAM_CNT_W-1:0] ram_cnt;
  } cbm_cfg_t;

  typedef struct packed {
    logic                  ram_en_we;
    logic                  rom_we;
    logic                  sel_we;
    logic                  clk_we;
    logic [CLK_IDX_W-1:0]  clk_idx;
    cbm_state_t            nxt;
    logic [BYTE_W-1:0]     clk_data;
  } cbm_upd_t;

endpackage

// ===== src/cbm_intf.sv =====
// ----------------------------------------------------------------------------
// cbm interfaces
// Request, response and configuration channels of the bank mapper.
// ----------------------------------------------------------------------------
interface cbm_req_if;
  import cbm_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] bus_address;
  logic [BYTE_W-1:0] write_byte;
  modport source (output valid, func, bus_address, write_byte, input ready);
  modport sink   (input valid, func, bus_address, write_byte, output ready);
endinterface

interface cbm_rsp_if;
  import cbm_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        target;
  logic [MAP_W-1:0]  mapped_address;
  logic [BYTE_W-1:0] read_byte;
  logic              ram_write;
  modport source (output valid, target, mapped_address, read_byte, ram_write,
                  input ready);
  modport sink   (input valid, target, mapped_address, read_byte, ram_write,
                  output ready);
endinterface

interface cbm_cfg_if;
  import cbm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/cbm_decode.sv =====
// ----------------------------------------------------------------------------
// cbm_decode
// Decodes one bus request against the cartridge areas, translates the
// address and produces the controller register updates.
// ----------------------------------------------------------------------------
module cbm_decode #(
  parameter int MaxRomBanks = cbm_pkg::MAX_ROM_BANKS_DEF
) (
  input  cbm_pkg::cbm_req_t                                  req_i,
  input  cbm_pkg::cbm_state_t                                st_i,
  input  cbm_pkg::cbm_cfg_t                                  cfg_i,
  input  logic [cbm_pkg::CLK_BYTES-1:0][cbm_pkg::BYTE_W-1:0] clk_bytes_i,
  output cbm_pkg::cbm_rsp_t                                  rsp_o,
  output cbm_pkg::cbm_upd_t                                  upd_o
);
  import cbm_pkg::*;

  logic [ROM_CNT_W-1:0]  rom_lim;
  logic [ROM_CNT_W-1:0]  rom_lim_m1;
  logic [ROM_BANK_W-1:0] rom_eff;
  logic [1:0]            ram_bank;
  logic [RAM_CNT_W-1:0]  ram_cnt_m1;
  logic [1:0]            ram_eff;
  logic [3:0]            clk_off;
  logic [CLK_IDX_W-1:0]  clk_idx;
  logic                  clk_sel;

  // zero or oversized bank count falls back to the maximum
  always_comb begin
    if (cfg_i.rom_cnt == '0 || cfg_i.rom_cnt > ROM_CNT_W'(MaxRomBanks)) begin
      rom_lim = ROM_CNT_W'(MaxRomBanks);
    end else begin
      rom_lim = cfg_i.rom_cnt;
    end
  end

  assign rom_lim_m1 = rom_lim - ROM_CNT_W'(1);
  assign rom_eff    = ({1'b0, st_i.rom_bank} >= rom_lim) ?
                      (st_i.rom_bank & rom_lim_m1[ROM_BANK_W-1:0]) : st_i.rom_bank;

  // a ram count of zero wraps the mask to all ones
  assign ram_bank   = st_i.ram_sel[1:0];
  assign ram_cnt_m1 = cfg_i.ram_cnt - RAM_CNT_W'(1);
  assign ram_eff    = ({1'b0, ram_bank} >= cfg_i.ram_cnt) ?
                      (ram_bank & ram_cnt_m1[1:0]) : ram_bank;

  assign clk_sel = (st_i.ram_sel >= CLK_SEL_FIRST) && (st_i.ram_sel <= CLK_SEL_LAST);
  assign clk_off = st_i.ram_sel - CLK_SEL_FIRST;
  assign clk_idx = clk_off[CLK_IDX_W-1:0];

  always_comb begin
    rsp_o              = '0;
    upd_o              = '0;
    upd_o.clk_idx      = clk_idx;
    upd_o.clk_data     = req_i.write_byte;
    upd_o.nxt.ram_en   = req_i.write_byte[3:0];
    upd_o.nxt.rom_bank = (req_i.write_byte[ROM_BANK_W-1:0] == '0) ?
                         ROM_BANK_W'(1) : req_i.write_byte[ROM_BANK_W-1:0];
    upd_o.nxt.ram_sel  = req_i.write_byte[3:0];
    upd_o.nxt.use_ram  = (req_i.write_byte <= RAM_SEL_MAX);
    rsp_o.target       = TGT_NONE;

    if (!req_i.bus_address[15]) begin
      if (!req_i.func) begin
        rsp_o.target = TGT_ROM;
        if (!req_i.bus_address[14]) begin
          rsp_o.mapped_address = MAP_W'(req_i.bus_address);
        end else begin
          rsp_o.mapped_address = {rom_eff, req_i.bus_address[13:0]};
        end
      end else begin
        rsp_o.target = TGT_ABSORB;
        case (req_i.bus_address[14:13])
          2'b00:   upd_o.ram_en_we = 1'b1;
          2'b01:   upd_o.rom_we    = 1'b1;
          2'b10:   upd_o.sel_we    = 1'b1;
          default: ;  // clock latch writes have no effect
        endcase
      end
    end else if (req_i.bus_address[15:13] == 3'b101) begin
      rsp_o.target = req_i.func ? TGT_ABSORB : TGT_DATA;
      if (st_i.ram_en == RAM_ENABLE_KEY) begin
        if (st_i.use_ram) begin
          rsp_o.target         = TGT_RAM;
          rsp_o.mapped_address = MAP_W'({ram_eff, req_i.bus_address[12:0]});
          rsp_o.ram_write      = req_i.func;
        end else if (clk_sel) begin
          if (req_i.func) begin
            upd_o.clk_we = 1'b1;
          end else begin
            rsp_o.read_byte = clk_bytes_i[clk_idx];
          end
        end
      end
    end
  end

endmodule

// ===== src/cartridge_bank_mapper_with_clock_regs_top.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_clock_regs_top
// Bank controller for a cartridge with ROM and RAM banking and a clock of five
// bytes. Every bus request returns one response: ROM reads and RAM accesses
// carry a translated byte address, clock reads return data, register
// writes are absorbed, and accesses outside the cartridge areas come back
// as not handled. One request is accepted per cycle while the output is not
// stalled. A request waits in the input register, passes a single decode
// stage and is held in the result register until its response is taken.
// Register writes from a request land as the request leaves the decode
// stage, so the very next request already sees them. While a response waits
// to be taken, the input register still takes one more request; further
// requests stall until the response goes. The user must write bank counts
// over the configuration channel only while idle, not enforced by the block.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_clock_regs_top #(
  parameter int MaxRomBanks = cbm_pkg::MAX_ROM_BANKS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbm_req_if.sink   in_i,
  cbm_rsp_if.source out_o,
  cbm_cfg_if.sink   cfg_i
);
  import cbm_pkg::*;

  cbm_req_t   s1_req_q;
  logic       s1_valid_q;
  cbm_rsp_t   out_q;
  logic       out_valid_q;
  cbm_state_t st_q;
  cbm_cfg_t   cfg_q;
  logic [CLK_BYTES-1:0][BYTE_W-1:0] clk_bytes_q;

  cbm_rsp_t dec_rsp;
  cbm_upd_t upd;
  logic     adv;
  logic     in_fire;

  assign adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_fire = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rom_cnt <= ROM_CNT_W'(MaxRomBanks);
      cfg_q.ram_cnt <= RAM_CNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ROM_BANK_COUNT: cfg_q.rom_cnt <= cfg_i.data;
        CFG_RAM_BANK_COUNT: cfg_q.ram_cnt <= cfg_i.data[RAM_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q.func        <= in_i.func;
      s1_req_q.bus_address <= in_i.bus_address;
      s1_req_q.write_byte  <= in_i.write_byte;
    end
  end

  cbm_decode #(
    .MaxRomBanks(MaxRomBanks)
  ) u_decode (
    .req_i      (s1_req_q),
    .st_i       (st_q),
    .cfg_i      (cfg_q),
    .clk_bytes_i(clk_bytes_q),
    .rsp_o      (dec_rsp),
    .upd_o      (upd)
  );

  // controller registers update as the request leaves the decode stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.rom_bank <= ROM_BANK_W'(1);
      st_q.ram_en   <= '0;
      st_q.ram_sel  <= '0;
      st_q.use_ram  <= 1'b0;
      clk_bytes_q   <= '0;
    end else if (adv) begin
      if (upd.ram_en_we) begin
        st_q.ram_en <= upd.nxt.ram_en;
      end
      if (upd.rom_we) begin
        st_q.rom_bank <= upd.nxt.rom_bank;
      end
      if (upd.sel_we) begin
        st_q.ram_sel <= upd.nxt.ram_sel;
        st_q.use_ram <= upd.nxt.use_ram;
      end
      if (upd.clk_we) begin
        clk_bytes_q[upd.clk_idx] <= upd.clk_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= dec_rsp;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.target         = out_q.target;
  assign out_o.mapped_address = out_q.mapped_address;
  assign out_o.read_byte      = out_q.read_byte;
  assign out_o.ram_write      = out_q.ram_write;

`ifndef ASSERT_OFF
  a_rom_bank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.rom_bank != '0)
    else $error("rom bank register holds zero");

  a_use_ram_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.use_ram |-> (st_q.ram_sel <= 4'd3))
    else $error("ram flag set with a clock select");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("decoded request lost before the result register");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |-> !in_i.ready)
    else $error("request taken while the input register is stalled");
`endif

endmodule

// ===== sim/tb_cartridge_bank_mapper_with_clock_regs_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_with_clock_regs_top
// Self-checking bench for the cartridge bank mapper. A directed table covers
// the address map edges, bank zero, enable and select corner cases and the
// clock bytes. Random bus traffic then runs under several ROM/RAM bank count
// settings. Responses are compared field by field against an in-bench
// mapper model, with random idle gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_with_clock_regs_top;
  import cbm_pkg::*;

  localparam logic RD = 1'b0;
  localparam logic WR = 1'b1;

  localparam int DIR_ROWS       = 27;
  localparam int NUM_PHASES     = 7;
  localparam int RAND_PER_PHASE = 215;
  localparam int MAX_IDLE       = 11;
  localparam int LONG_HOLD      = 300;
  localparam int PIPE_DRAIN     = 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_PRINTS     = 50;

  localparam cbm_rsp_t NO_RSP = '0;

  typedef struct packed {
    logic     typed;
    cbm_req_t acc;
    cbm_rsp_t rsp;
  } dir_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rom_cnt;
    logic [BYTE_W-1:0] ram_cnt;
  } bank_setting_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cbm_req_if req_if ();
  cbm_rsp_if rsp_if ();
  cbm_cfg_if cfg_if ();

  cartridge_bank_mapper_with_clock_regs_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // mapper model state and bank counts
  logic [ROM_BANK_W-1:0] rom_bank_q;
  logic [3:0]            ram_en_q;
  logic [3:0]            ram_sel_q;
  logic                  use_ram_q;
  logic [BYTE_W-1:0]     clk_bytes_q [CLK_BYTES];
  logic [ROM_CNT_W-1:0]  rom_cnt_q;
  logic [RAM_CNT_W-1:0]  ram_cnt_q;

  cbm_rsp_t expected_rsp_q [$];

  int  mismatch_cnt;
  int  sent_cnt;
  int  checked_cnt;
  int  ram_hit_cnt;
  int  cycle_cnt;
  bit  sender_burst;
  bit  recv_burst;
  bit  hold_off_req;

  dir_row_t      dir_rows [DIR_ROWS];
  bank_setting_t settings [NUM_PHASES];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic cbm_rsp_t map_access(cbm_req_t acc);
    cbm_rsp_t              rsp;
    int unsigned           cnt;
    logic [ROM_BANK_W-1:0] bank;
    logic [RAM_CNT_W-1:0]  rbank;
    rsp = '0;
    if (!acc.bus_address[15]) begin
      if (acc.func == RD) begin
        rsp.target = TGT_ROM;
        if (!acc.bus_address[14]) begin
          rsp.mapped_address = MAP_W'(acc.bus_address);
        end else begin
          cnt = rom_cnt_q;
          if (cnt == 0 || cnt > MAX_ROM_BANKS_DEF) cnt = MAX_ROM_BANKS_DEF;
          bank = rom_bank_q;
          // oversized bank wraps by the count mask, may land on bank 0
          if (bank >= cnt) bank = bank & ROM_BANK_W'(cnt - 1);
          rsp.mapped_address = {bank, acc.bus_address[13:0]};
        end
      end else begin
        rsp.target = TGT_ABSORB;
        case (acc.bus_address[14:13])
          2'd0: ram_en_q = acc.write_byte[3:0];
          2'd1: begin
            rom_bank_q = acc.write_byte[ROM_BANK_W-1:0];
            if (rom_bank_q == '0) rom_bank_q = 7'd1;
          end
          2'd2: begin
            ram_sel_q = acc.write_byte[3:0];
            use_ram_q = (acc.write_byte <= RAM_SEL_MAX);
          end
          default: ;  // clock latch, nothing to do
        endcase
      end
    end else if (acc.bus_address[15:13] == 3'b101) begin
      rsp.target = acc.func ? TGT_ABSORB : TGT_DATA;
      if (ram_en_q == RAM_ENABLE_KEY) begin
        if (use_ram_q) begin
          rbank = RAM_CNT_W'(ram_sel_q[1:0]);
          // zero count wraps the mask to all ones
          if (rbank >= ram_cnt_q) rbank = rbank & (ram_cnt_q - 3'd1);
          rsp.mapped_address = MAP_W'({rbank, acc.bus_address[12:0]});
          rsp.target         = TGT_RAM;
          rsp.ram_write      = acc.func;
        end else if (ram_sel_q >= CLK_SEL_FIRST && ram_sel_q <= CLK_SEL_LAST) begin
          if (acc.func) clk_bytes_q[ram_sel_q - CLK_SEL_FIRST] = acc.write_byte;
          else rsp.read_byte = clk_bytes_q[ram_sel_q - CLK_SEL_FIRST];
        end
      end
    end
    return rsp;
  endfunction

  function automatic cbm_req_t random_access();
    cbm_req_t    acc;
    int unsigned pick;
    pick            = $urandom_range(0, 99);
    acc.func        = RD;
    acc.bus_address = ADDR_W'($urandom_range(0, 16'hFFFF));
    acc.write_byte  = BYTE_W'($urandom_range(0, 255));
    if (pick < 20) begin
      acc.bus_address = ADDR_W'($urandom_range(0, 16'h7FFF));
    end else if (pick < 28) begin
      acc.func        = WR;
      acc.bus_address = ADDR_W'($urandom_range(0, 16'h1FFF));
      if ($urandom_range(0, 9) < 7) acc.write_byte[3:0] = RAM_ENABLE_KEY;
    end else if (pick < 36) begin
      acc.func        = WR;
      acc.bus_address = ADDR_W'($urandom_range(16'h2000, 16'h3FFF));
    end else if (pick < 48) begin
      acc.func        = WR;
      acc.bus_address = ADDR_W'($urandom_range(16'h4000, 16'h5FFF));
      case ($urandom_range(0, 4))
        0, 1:    acc.write_byte      = BYTE_W'($urandom_range(0, 3));
        2, 3:    acc.write_byte[3:0] = 4'($urandom_range(8, 12));
        default: ;
      endcase
    end else if (pick < 52) begin
      acc.func        = WR;
      acc.bus_address = ADDR_W'($urandom_range(16'h6000, 16'h7FFF));
    end else if (pick < 88) begin
      acc.func        = 1'($urandom_range(0, 1));
      acc.bus_address = ADDR_W'($urandom_range(16'hA000, 16'hBFFF));
    end else begin
      acc.func = 1'($urandom_range(0, 1));
    end
    return acc;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS)
      $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic send_access(cbm_req_t acc, logic typed, cbm_rsp_t typed_rsp);
    int       gap;
    cbm_rsp_t want;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= acc.func;
    req_if.bus_address <= acc.bus_address;
    req_if.write_byte  <= acc.write_byte;
    do @(posedge clk_i); while (!req_if.ready);
    want = map_access(acc);
    if (want.target == TGT_RAM) ram_hit_cnt++;
    expected_rsp_q.push_back(typed ? typed_rsp : want);
    sent_cnt++;
  endtask

  task automatic set_bank_counts(bank_setting_t s);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_ROM_BANK_COUNT;
    cfg_if.data  <= s.rom_cnt;
    do @(posedge clk_i); while (!cfg_if.ready);
    rom_cnt_q = s.rom_cnt;
    cfg_if.index <= CFG_RAM_BANK_COUNT;
    cfg_if.data  <= s.ram_cnt;
    do @(posedge clk_i); while (!cfg_if.ready);
    ram_cnt_q = s.ram_cnt[RAM_CNT_W-1:0];
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // response side: random ready stalls, one long hold-off
  initial begin
    int       stall;
    int       hold_cnt;
    bit       held;
    cbm_rsp_t got;
    cbm_rsp_t want;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold_off_req && !held) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) @(posedge clk_i);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      got = {rsp_if.target, rsp_if.mapped_address, rsp_if.read_byte, rsp_if.ram_write};
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("response with nothing outstanding", 32'(got.target), 0);
      end else begin
        want = expected_rsp_q.pop_front();
        checked_cnt++;
        if (got.target !== want.target)
          report_mismatch("target", 32'(got.target), 32'(want.target));
        if (got.mapped_address !== want.mapped_address)
          report_mismatch("mapped_address", 32'(got.mapped_address),
                          32'(want.mapped_address));
        if (got.read_byte !== want.read_byte)
          report_mismatch("read_byte", 32'(got.read_byte), 32'(want.read_byte));
        if (got.ram_write !== want.ram_write)
          report_mismatch("ram_write", 32'(got.ram_write), 32'(want.ram_write));
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles", cycle_cnt);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int ph;
    int i;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.func        <= RD;
    req_if.bus_address <= '0;
    req_if.write_byte  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_ROM_BANK_COUNT;
    cfg_if.data        <= '0;
    mismatch_cnt = 0;
    sent_cnt     = 0;
    checked_cnt  = 0;
    ram_hit_cnt  = 0;
    sender_burst = 1'b0;
    recv_burst   = 1'b0;
    hold_off_req = 1'b0;

    rom_bank_q = 7'd1;
    ram_en_q   = '0;
    ram_sel_q  = '0;
    use_ram_q  = 1'b0;
    for (i = 0; i < CLK_BYTES; i++) clk_bytes_q[i] = '0;
    rom_cnt_q  = ROM_CNT_W'(MAX_ROM_BANKS_DEF);
    ram_cnt_q  = RAM_CNT_RST;

    dir_rows = '{
      '{1'b1, '{RD, 16'h0000, 8'h00}, '{TGT_ROM,    21'h000000, 8'h00, 1'b0}},
      '{1'b1, '{RD, 16'h4000, 8'h00}, '{TGT_ROM,    21'h004000, 8'h00, 1'b0}},
      '{1'b1, '{RD, 16'h7FFF, 8'h00}, '{TGT_ROM,    21'h007FFF, 8'h00, 1'b0}},
      '{1'b1, '{RD, 16'h8000, 8'h00}, '{TGT_NONE,   21'h000000, 8'h00, 1'b0}},
      '{1'b1, '{WR, 16'h9FFF, 8'hFF}, '{TGT_NONE,   21'h000000, 8'h00, 1'b0}},
      '{1'b1, '{WR, 16'hFFFF, 8'h00}, '{TGT_NONE,   21'h000000, 8'h00, 1'b0}},
      // external RAM still disabled
      '{1'b1, '{RD, 16'hA000, 8'h00}, '{TGT_DATA,   21'h000000, 8'h00, 1'b0}},
      '{1'b1, '{WR, 16'hBFFF, 8'hFF}, '{TGT_ABSORB, 21'h000000, 8'h00, 1'b0}},
      // bank zero selects bank one
      '{1'b1, '{WR, 16'h2000, 8'h00}, '{TGT_ABSORB, 21'h000000, 8'h00, 1'b0}},
      '{1'b1, '{RD, 16'h4000, 8'h00}, '{TGT_ROM,    21'h004000, 8'h00, 1'b0}},
      '{1'b1, '{WR, 16'h3FFF, 8'hFF}, '{TGT_ABSORB, 21'h000000, 8'h00, 1'b0}},
      '{1'b1, '{RD, 16'h7FFF, 8'h00}, '{TGT_ROM,    21'h1FFFFF, 8'h00, 1'b0}},
      '{1'b1, '{WR, 16'h0000, 8'h0A}, '{TGT_ABSORB, 21'h000000, 8'h00, 1'b0}},
      '{1'b1, '{WR, 16'h4000, 8'h03}, '{TGT_ABSORB, 21'h000000, 8'h00, 1'b0}},
      '{1'b0, '{WR, 16'hBFFF, 8'h5A}, NO_RSP},
      '{1'b0, '{RD, 16'hA000, 8'h00}, NO_RSP},
      // select nibble 3 but high bits clear the RAM flag
      '{1'b1, '{WR, 16'h5FFF, 8'hF3}, '{TGT_ABSORB, 21'h000000, 8'h00, 1'b0}},
      '{1'b1, '{RD, 16'hA000, 8'h00}, '{TGT_DATA,   21'h000000, 8'h00, 1'b0}},
      '{1'b1, '{WR, 16'h4000, 8'h08}, '{TGT_ABSORB, 21'h000000, 8'h00, 1'b0}},
      '{1'b0, '{WR, 16'hA123, 8'hA5}, NO_RSP},
      '{1'b0, '{RD, 16'hB000, 8'h00}, NO_RSP},
      '{1'b1, '{WR, 16'h4000, 8'h0C}, '{TGT_ABSORB, 21'h000000, 8'h00, 1'b0}},
      '{1'b0, '{WR, 16'hA000, 8'hFF}, NO_RSP},
      '{1'b0, '{RD, 16'hA000, 8'h00}, NO_RSP},
      // clock latch write has no effect
      '{1'b1, '{WR, 16'h6000, 8'hFF}, '{TGT_ABSORB, 21'h000000, 8'h00, 1'b0}},
      '{1'b1, '{WR, 16'h1FFF, 8'h1B}, '{TGT_ABSORB, 21'h000000, 8'h00, 1'b0}},
      '{1'b1, '{RD, 16'hBFFF, 8'h00}, '{TGT_DATA,   21'h000000, 8'h00, 1'b0}}
    };

    // first entry is the reset setting; zero counts and oversized ones included
    settings = '{
      '{8'd128, 8'd4}, '{8'd2, 8'd1}, '{8'd255, 8'd0}, '{8'd0, 8'd7},
      '{8'd64, 8'h0A}, '{8'd96, 8'd3}, '{8'd128, 8'd4}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      send_access(dir_rows[i].acc, dir_rows[i].typed, dir_rows[i].rsp);
    req_if.valid <= 1'b0;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      if (ph > 0) set_bank_counts(settings[ph]);
      if (ph == 2) begin
        // back the output up while requests keep coming
        hold_off_req = 1'b1;
        sender_burst = 1'b1;
      end
      for (i = 0; i < RAND_PER_PHASE; i++) begin
        if (i % 40 == 39) begin
          sender_burst = ($urandom_range(0, 3) == 0);
          recv_burst   = ($urandom_range(0, 3) == 0);
        end
        send_access(random_access(), 1'b0, NO_RSP);
      end
      req_if.valid <= 1'b0;
    end

    wait_drained();
    $display("Sent %0d bus requests and checked %0d responses over %0d bank count settings",
             sent_cnt, checked_cnt, NUM_PHASES);
    $display("%0d responses were mapped RAM accesses, %0d field mismatches",
             ram_hit_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
